// ===== src/dqm_pkg.sv =====
`default_nettype none

package dqm_pkg;

  typedef enum logic [2:0] {
    REQ_ADD_FRONT = 3'd0,
    REQ_ADD_BACK  = 3'd1,
    REQ_ADD_MID   = 3'd2,
    REQ_REM_FRONT = 3'd3,
    REQ_REM_BACK  = 3'd4,
    REQ_REM_MID   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  localparam logic signed [VALUE_W-1:0] VALUE_EMPTY = -32'sd1;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

endpackage

`default_nettype wire

// ===== src/dqm_if.sv =====
`default_nettype none

interface dqm_req_if;
  logic                valid;
  logic                ready;
  logic [2:0]          req_type;
  logic signed [31:0]  value_in;

  modport source (output valid, req_type, value_in, input ready);
  modport sink   (input valid, req_type, value_in, output ready);
endinterface

interface dqm_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  value_out;
  logic [1:0]          status;
  logic [4:0]          entry_count;

  modport source (output valid, value_out, status, entry_count, input ready);
  modport sink   (input valid, value_out, status, entry_count, output ready);
endinterface

`default_nettype wire

// ===== src/deque_with_middle_insert_remove.sv =====
`default_nettype none
// Bounded deque of signed 32-bit words with front, back and middle add/remove.
// req_i (sink): req_type and value_in. rsp_o (source): value_out, status and
// entry_count, exactly one response word per request word, in order.
// The middle index is floor((n-1)/2), or 1 when n is 2; a middle add lands
// just after it, a middle remove takes it.
// Storage is a row of DEPTH cells; every cell shifts left, right or holds in
// the cycle a request is taken, so each request finishes as it is accepted.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one request per cycle while rsp_o is taken every cycle.
// A response word waits in the output register while the receiver stalls;
// req_i.ready stays high if that register is taken in the same cycle, so
// a new request can be accepted as the old response leaves.
// Reset empties the store and drops any pending response; the cell contents
// are not cleared, only the count.
// An add to a full store returns status full, a remove from an empty store
// returns -1 with status empty. Request codes 6 and 7 return ok, value 0.
module deque_with_middle_insert_remove #(
  parameter int unsigned DEPTH = 16
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  dqm_req_if.sink  req_i,
  dqm_rsp_if.source rsp_o
);
  import dqm_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [1:0]       status_q, status_d;
  logic [COUNT_W-1:0] entry_q;
  logic [EXT_W-1:0] count_ext;

  logic fire, is_add, is_rem, full, empty, do_ins, do_rem;
  logic [CNT_W-1:0] mid_cnt;
  logic [IDX_W-1:0] mid, pos;
  logic signed [VALUE_W-1:0] slots [DEPTH];
  logic signed [VALUE_W-1:0] rd_val;
  cell_op_t op;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  assign full   = (count_q == FULL_CNT);
  assign empty  = (count_q == '0);
  assign is_add = (req_i.req_type inside {REQ_ADD_FRONT, REQ_ADD_BACK, REQ_ADD_MID});
  assign is_rem = (req_i.req_type inside {REQ_REM_FRONT, REQ_REM_BACK, REQ_REM_MID});
  assign do_ins = fire && is_add && !full;
  assign do_rem = fire && is_rem && !empty;

  assign mid_cnt = (count_q == CNT_W'(2)) ? CNT_W'(1) : ((count_q - CNT_W'(1)) >> 1);
  assign mid     = mid_cnt[IDX_W-1:0];

  always_comb begin
    case (req_i.req_type)
      REQ_ADD_FRONT: pos = '0;
      REQ_ADD_BACK:  pos = count_q[IDX_W-1:0];
      REQ_ADD_MID:   pos = empty ? '0 : (mid + IDX_W'(1));
      REQ_REM_FRONT: pos = '0;
      REQ_REM_BACK:  pos = count_q[IDX_W-1:0] - IDX_W'(1);
      REQ_REM_MID:   pos = mid;
      default:       pos = '0;
    endcase
  end

  assign op.ins = do_ins;
  assign op.rem = do_rem;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dqm_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .pos_i     (pos),
      .ins_val_i (req_i.value_in),
      .left_i    ((i == 0) ? req_i.value_in : slots[(i == 0) ? 0 : i - 1]),
      .right_i   (slots[(i == DEPTH - 1) ? i : i + 1]),
      .slot_o    (slots[i])
    );
  end

  // removed word: and-or select over the row
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (IDX_W'(i) == pos) begin
        rd_val = rd_val | slots[i];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    value_d  = '0;
    status_d = ST_OK;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
      value_d = rd_val;
    end else if (is_add) begin
      status_d = ST_FULL;
    end else if (is_rem) begin
      value_d  = VALUE_EMPTY;
      status_d = ST_EMPTY;
    end
  end

  assign count_ext = EXT_W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      value_q  <= value_d;
      status_q <= status_d;
      entry_q  <= count_ext[COUNT_W-1:0];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.value_out   = value_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_count = entry_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("count above depth");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow count");

  a_rem_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rem |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not shrink count");

  a_fire_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted request without response");

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(op.ins && op.rem))
    else $error("insert and remove together");
`endif

endmodule

`default_nettype wire

// ===== src/dqm_cell.sv =====
`default_nettype none

module dqm_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 4
) (
  input  wire                        clk_i,
  input  wire dqm_pkg::cell_op_t     op_i,
  input  wire [IDX_W-1:0]            pos_i,
  input  wire signed [31:0]          ins_val_i,
  input  wire signed [31:0]          left_i,
  input  wire signed [31:0]          right_i,
  output logic signed [31:0]         slot_o
);
  import dqm_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [VALUE_W-1:0] slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (op_i.ins) begin
      if (MY_IDX == pos_i) begin
        slot_d = ins_val_i;
      end else if (MY_IDX > pos_i) begin
        slot_d = left_i;
      end
    end else if (op_i.rem) begin
      if (MY_IDX >= pos_i) begin
        slot_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire
